/* sv/ptt_pkg.sv */
//------------------------------------------------------------------------------
// ptt_pkg
// Types and codes shared by the pending transaction table modules.
//------------------------------------------------------------------------------
`default_nettype none

package ptt_pkg;

  typedef enum logic [3:0] {
    ACT_ADD       = 4'd0,
    ACT_GET_ADDR  = 4'd1,
    ACT_CHK_ADDR  = 4'd2,
    ACT_CHK_SEC   = 4'd3,
    ACT_DEL_ADDR  = 4'd4,
    ACT_CHK_TAG   = 4'd5,
    ACT_DEL_TAG   = 4'd6,
    ACT_COUNT     = 4'd7,
    ACT_CLEAR     = 4'd8
  } action_e;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  localparam logic [1:0] MODE_SHORT = 2'd2;
  localparam logic [1:0] MODE_EXT   = 2'd3;

  typedef struct packed {
    logic [3:0]  action;
    logic [1:0]  addr_mode;
    logic [63:0] address;
    logic [15:0] packet_tag;
    logic        use_tag;
    logic [7:0]  handle;
    logic [31:0] keep_time;
    logic [31:0] now;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] found_tag;
    logic [3:0]  entry_count;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PURGE,
    S_EXEC,
    S_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic purge;
    logic exec;
  } ctrl_t;

endpackage

`default_nettype wire

/* sv/ptt_datapath.sv */
//------------------------------------------------------------------------------
// ptt_datapath
// Entry table with per-slot compare, purge compaction, add, delete and result.
//------------------------------------------------------------------------------
`default_nettype none

module ptt_datapath #(
  parameter int TABLE_DEPTH = 8
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  ptt_pkg::ctrl_t       ctrl_i,
  input  ptt_pkg::in_item_t    item_i,
  output ptt_pkg::out_item_t   result_o
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  ptt_pkg::in_item_t item_q;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [1:0]  mode_q    [TABLE_DEPTH];
  logic [63:0] addr_q    [TABLE_DEPTH];
  logic [15:0] tag_q     [TABLE_DEPTH];
  logic [7:0]  handle_q  [TABLE_DEPTH];
  logic [31:0] expiry_q  [TABLE_DEPTH];
  logic [1:0]  mode_d    [TABLE_DEPTH];
  logic [63:0] addr_d    [TABLE_DEPTH];
  logic [15:0] tag_d     [TABLE_DEPTH];
  logic [7:0]  handle_d  [TABLE_DEPTH];
  logic [31:0] expiry_d  [TABLE_DEPTH];
  ptt_pkg::out_item_t res_q, res_d;

  logic [TABLE_DEPTH-1:0] amatch, tmatch, keep;
  logic [IW-1:0] dst [TABLE_DEPTH];
  logic [CW-1:0] cnt;
  logic [32:0]   exp_sum;
  logic [31:0]   exp_sat;

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      amatch[i] = valid_q[i] && (mode_q[i] == item_q.addr_mode) &&
                  (((item_q.addr_mode == ptt_pkg::MODE_SHORT) &&
                    (addr_q[i][15:0] == item_q.address[15:0])) ||
                   ((item_q.addr_mode == ptt_pkg::MODE_EXT) &&
                    (addr_q[i] == item_q.address)));
      tmatch[i] = valid_q[i] && (item_q.use_tag ? (tag_q[i] == item_q.packet_tag)
                                                : (handle_q[i] == item_q.handle));
      keep[i]   = valid_q[i] && !(item_q.now > expiry_q[i]);
    end
  end

  // prefix counts give each kept entry its packed slot
  always_comb begin
    cnt = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      dst[i] = cnt[IW-1:0];
      if (keep[i]) cnt = cnt + 1'b1;
    end
  end

  assign exp_sum = {1'b0, item_q.now} + {1'b0, item_q.keep_time};
  assign exp_sat = exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];

  always_comb begin
    logic [CW-1:0] n;
    logic          hit, second;
    logic [IW-1:0] k;
    logic [TABLE_DEPTH-1:0] m;
    n = '0;
    hit = 1'b0;
    second = 1'b0;
    k = '0;
    m = '0;
    valid_d = valid_q;
    mode_d = mode_q;
    addr_d = addr_q;
    tag_d = tag_q;
    handle_d = handle_q;
    expiry_d = expiry_q;
    res_d = res_q;
    if (ctrl_i.purge) begin
      valid_d = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (keep[i]) begin
          valid_d[dst[i]] = 1'b1;
          mode_d[dst[i]] = mode_q[i];
          addr_d[dst[i]] = addr_q[i];
          tag_d[dst[i]] = tag_q[i];
          handle_d[dst[i]] = handle_q[i];
          expiry_d[dst[i]] = expiry_q[i];
        end
      end
    end else if (ctrl_i.exec) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (valid_q[i]) n = n + 1'b1;
      end
      if (item_q.action == ptt_pkg::ACT_DEL_TAG) m = tmatch;
      else m = amatch;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
        if (m[i]) begin
          hit = 1'b1;
          k = IW'(i);
        end
      end
      // any other address match lies after the first one
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (amatch[i] && (IW'(i) != k)) second = 1'b1;
      end
      res_d.status = ptt_pkg::ST_NOTFOUND;
      res_d.found_tag = '0;
      case (item_q.action)
        ptt_pkg::ACT_ADD: begin
          if (n >= CW'(TABLE_DEPTH)) begin
            res_d.status = ptt_pkg::ST_FULL;
          end else begin
            valid_d[n[IW-1:0]] = 1'b1;
            mode_d[n[IW-1:0]] = item_q.addr_mode;
            addr_d[n[IW-1:0]] = item_q.address;
            tag_d[n[IW-1:0]] = item_q.packet_tag;
            handle_d[n[IW-1:0]] = item_q.handle;
            expiry_d[n[IW-1:0]] = exp_sat;
            n = n + 1'b1;
            res_d.status = ptt_pkg::ST_OK;
          end
        end
        ptt_pkg::ACT_GET_ADDR: begin
          if (hit) begin
            res_d.status = ptt_pkg::ST_OK;
            res_d.found_tag = tag_q[k];
          end
        end
        ptt_pkg::ACT_CHK_ADDR: if (hit) res_d.status = ptt_pkg::ST_OK;
        ptt_pkg::ACT_CHK_SEC: if (hit && second) res_d.status = ptt_pkg::ST_OK;
        ptt_pkg::ACT_CHK_TAG: if (|tmatch) res_d.status = ptt_pkg::ST_OK;
        ptt_pkg::ACT_DEL_ADDR, ptt_pkg::ACT_DEL_TAG: begin
          if (hit) begin
            // shift younger entries down over the removed slot
            for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
              if (IW'(i) >= k) begin
                valid_d[i] = valid_q[i+1];
                mode_d[i] = mode_q[i+1];
                addr_d[i] = addr_q[i+1];
                tag_d[i] = tag_q[i+1];
                handle_d[i] = handle_q[i+1];
                expiry_d[i] = expiry_q[i+1];
              end
            end
            valid_d[TABLE_DEPTH-1] = 1'b0;
            n = n - 1'b1;
            res_d.status = ptt_pkg::ST_OK;
          end
        end
        ptt_pkg::ACT_COUNT: res_d.status = ptt_pkg::ST_OK;
        ptt_pkg::ACT_CLEAR: begin
          valid_d = '0;
          n = '0;
          res_d.status = ptt_pkg::ST_OK;
        end
        default: res_d.status = ptt_pkg::ST_NOTFOUND;
      endcase
      res_d.entry_count = 4'(n);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) item_q <= item_i;
    mode_q <= mode_d;
    addr_q <= addr_d;
    tag_q <= tag_d;
    handle_q <= handle_d;
    expiry_q <= expiry_d;
    res_q <= res_d;
  end

  assign result_o = res_q;

endmodule

`default_nettype wire

/* sv/ptt_ctrl.sv */
//------------------------------------------------------------------------------
// ptt_ctrl
// Sequencer: load item, optional purge pass, execute, hold result.
//------------------------------------------------------------------------------
`default_nettype none

module ptt_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire  [3:0]         in_action_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output ptt_pkg::ctrl_t     ctrl_o
);

  ptt_pkg::state_e state_q, state_d;
  logic            purge_q, purge_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptt_pkg::S_IDLE;
      purge_q <= 1'b0;
    end else begin
      state_q <= state_d;
      purge_q <= purge_d;
    end
  end

  always_comb begin
    state_d = state_q;
    purge_d = purge_q;
    ctrl_o = '0;
    in_stall_o = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ptt_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          purge_d = (in_action_i == ptt_pkg::ACT_ADD) ||
                    (in_action_i == ptt_pkg::ACT_CHK_ADDR) ||
                    (in_action_i == ptt_pkg::ACT_CHK_TAG) ||
                    (in_action_i == ptt_pkg::ACT_COUNT);
          state_d = ptt_pkg::S_PURGE;
        end
      end
      ptt_pkg::S_PURGE: begin
        ctrl_o.purge = purge_q;
        state_d = ptt_pkg::S_EXEC;
      end
      ptt_pkg::S_EXEC: begin
        ctrl_o.exec = 1'b1;
        state_d = ptt_pkg::S_OUT;
      end
      ptt_pkg::S_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) state_d = ptt_pkg::S_IDLE;
      end
      default: state_d = ptt_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* sv/pending_transaction_table_unit.sv */
//------------------------------------------------------------------------------
// pending_transaction_table_unit
// Insertion-ordered table of pending indirect transactions.
//------------------------------------------------------------------------------
// An item on the in channel carries one action (add, lookups, deletes, count,
// clear) with its address, tag, handle and times. It is taken when in_valid_i
// is high and in_stall_o low. Exactly one result item follows on the out
// channel, held steady with out_valid_o until out_stall_i is low.
// After the accepting edge the item passes a purge state, in which one pass
// compacts expired entries (idle for actions that do not purge), then an
// execute state in which all slots compare in parallel and the result is
// registered. The result is held until taken and a new item is accepted the
// cycle after, so the unit takes no new item while one is still in flight.
// Reset clears all entry valid bits and the sequencer; the table starts empty.
//------------------------------------------------------------------------------
`default_nettype none

module pending_transaction_table_unit #(
  parameter int TABLE_DEPTH = 8
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  ptt_pkg::in_item_t      in_data_i,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output ptt_pkg::out_item_t     out_data_o
);

  ptt_pkg::ctrl_t ctrl;

  ptt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_action_i (in_data_i.action),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctrl_o      (ctrl)
  );

  ptt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .item_i   (in_data_i),
    .result_o (out_data_o)
  );

endmodule

`default_nettype wire

/* bench/pending_transaction_table_unit_test.sv */
//------------------------------------------------------------------------------
// pending_transaction_table_unit_test
// Drives random and directed table actions into the pending transaction table
// and checks every result item against a behavioral copy of the table.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps

module pending_transaction_table_unit_test;

  localparam int DEPTH = 8;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  ptt_pkg::in_item_t  in_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  ptt_pkg::out_item_t out_data_o;

  pending_transaction_table_unit #(.TABLE_DEPTH(DEPTH)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  always #4 clk_i = ~clk_i;

  typedef struct {
    logic [1:0]  mode;
    logic [63:0] addr;
    logic [15:0] tag;
    logic [7:0]  hdl;
    logic [31:0] expiry;
  } slot_t;

  slot_t              tbl[$];
  ptt_pkg::out_item_t expected_results[$];
  int                 errors = 0;
  int                 send_idle = 0;
  int                 recv_stall = 0;

  // recent values so that lookups hit often
  logic [63:0] addr_pool[4];
  logic [15:0] tag_pool[4];
  logic [7:0]  hdl_pool[4];
  logic [31:0] clock_ticks = 32'd100;

  function automatic bit addr_hit(slot_t s, logic [1:0] m, logic [63:0] a);
    if (s.mode != m) return 0;
    if (m == ptt_pkg::MODE_SHORT) return s.addr[15:0] == a[15:0];
    if (m == ptt_pkg::MODE_EXT) return s.addr == a;
    return 0;
  endfunction

  function automatic int first_addr(int from, logic [1:0] m, logic [63:0] a);
    for (int i = from; i < tbl.size(); i++)
      if (addr_hit(tbl[i], m, a)) return i;
    return -1;
  endfunction

  function automatic int first_tag(ptt_pkg::in_item_t it);
    for (int i = 0; i < tbl.size(); i++)
      if (it.use_tag ? tbl[i].tag == it.packet_tag : tbl[i].hdl == it.handle) return i;
    return -1;
  endfunction

  function automatic void drop_expired(logic [31:0] t);
    slot_t kept[$];
    foreach (tbl[i]) if (!(t > tbl[i].expiry)) kept.push_back(tbl[i]);
    tbl = kept;
  endfunction

  function automatic ptt_pkg::out_item_t table_action(ptt_pkg::in_item_t it);
    ptt_pkg::out_item_t r;
    slot_t s;
    logic [32:0] sum;
    int k;
    r = '{status: ptt_pkg::ST_NOTFOUND, found_tag: '0, entry_count: '0};
    case (it.action)
      ptt_pkg::ACT_ADD: begin
        drop_expired(it.now);
        if (tbl.size() >= DEPTH) begin
          r.status = ptt_pkg::ST_FULL;
        end else begin
          sum = {1'b0, it.now} + {1'b0, it.keep_time};
          s.mode = it.addr_mode; s.addr = it.address; s.tag = it.packet_tag;
          s.hdl = it.handle; s.expiry = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          tbl.push_back(s);
          r.status = ptt_pkg::ST_OK;
        end
      end
      ptt_pkg::ACT_GET_ADDR: begin
        k = first_addr(0, it.addr_mode, it.address);
        if (k >= 0) begin
          r.status = ptt_pkg::ST_OK; r.found_tag = tbl[k].tag;
        end
      end
      ptt_pkg::ACT_CHK_ADDR: begin
        drop_expired(it.now);
        if (first_addr(0, it.addr_mode, it.address) >= 0) r.status = ptt_pkg::ST_OK;
      end
      ptt_pkg::ACT_CHK_SEC: begin
        k = first_addr(0, it.addr_mode, it.address);
        if (k >= 0 && first_addr(k + 1, it.addr_mode, it.address) >= 0)
          r.status = ptt_pkg::ST_OK;
      end
      ptt_pkg::ACT_DEL_ADDR: begin
        k = first_addr(0, it.addr_mode, it.address);
        if (k >= 0) begin
          tbl.delete(k); r.status = ptt_pkg::ST_OK;
        end
      end
      ptt_pkg::ACT_CHK_TAG: begin
        drop_expired(it.now);
        if (first_tag(it) >= 0) r.status = ptt_pkg::ST_OK;
      end
      ptt_pkg::ACT_DEL_TAG: begin
        k = first_tag(it);
        if (k >= 0) begin
          tbl.delete(k); r.status = ptt_pkg::ST_OK;
        end
      end
      ptt_pkg::ACT_COUNT: begin
        drop_expired(it.now);
        r.status = ptt_pkg::ST_OK;
      end
      ptt_pkg::ACT_CLEAR: begin
        tbl.delete();
        r.status = ptt_pkg::ST_OK;
      end
      default: r.status = ptt_pkg::ST_NOTFOUND;
    endcase
    r.entry_count = 4'(tbl.size());
    return r;
  endfunction

  // valid stays high after the accept until the next item or the drain
  task automatic send_item(ptt_pkg::in_item_t it);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_data_i <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_results.push_back(table_action(it));
    @(negedge clk_i);
  endtask

  // receiver stall and result check
  always @(negedge clk_i)
    out_stall_i <= (recv_stall > 0) && ($urandom_range(99) < recv_stall);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, out_data_o);
        errors++;
      end else begin
        ptt_pkg::out_item_t e;
        e = expected_results.pop_front();
        if (out_data_o.status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime, e.status,
                   out_data_o.status);
          errors++;
        end
        if (out_data_o.found_tag !== e.found_tag) begin
          $display("%0t: found_tag expected %h actual %h", $realtime, e.found_tag,
                   out_data_o.found_tag);
          errors++;
        end
        if (out_data_o.entry_count !== e.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d", $realtime,
                   e.entry_count, out_data_o.entry_count);
          errors++;
        end
      end
    end
  end

  function automatic ptt_pkg::in_item_t make_item(ptt_pkg::action_e a, logic [1:0] m,
                                                  logic [63:0] ad, logic [15:0] tg,
                                                  logic ut, logic [7:0] h,
                                                  logic [31:0] keep, logic [31:0] t);
    ptt_pkg::in_item_t it;
    it.action = a; it.addr_mode = m; it.address = ad; it.packet_tag = tg;
    it.use_tag = ut; it.handle = h; it.keep_time = keep; it.now = t;
    return it;
  endfunction

  function automatic ptt_pkg::in_item_t random_item();
    ptt_pkg::in_item_t it;
    logic [159:0] raw;
    int p;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(ptt_pkg::in_item_t)-1:0];
    p = $urandom_range(99);
    // time mostly creeps forward, sometimes jumps anywhere
    if (p < 5) clock_ticks = $urandom;
    else clock_ticks = clock_ticks + $urandom_range(20);
    it.now = clock_ticks;
    if ($urandom_range(3) != 0) it.keep_time = $urandom_range(200);
    it.addr_mode = ($urandom_range(9) == 0) ? 2'($urandom_range(1))
                                             : ($urandom_range(1) ? ptt_pkg::MODE_SHORT
                                                                  : ptt_pkg::MODE_EXT);
    if ($urandom_range(3) != 0) begin
      it.address = addr_pool[$urandom_range(3)];
      // short mode compares only the low half-word
      if (it.addr_mode == ptt_pkg::MODE_SHORT && $urandom_range(1))
        it.address[63:16] = 48'($urandom);
    end
    if ($urandom_range(3) != 0) it.packet_tag = tag_pool[$urandom_range(3)];
    if ($urandom_range(3) != 0) it.handle = hdl_pool[$urandom_range(3)];
    p = $urandom_range(99);
    if (p < 30) it.action = ptt_pkg::ACT_ADD;
    else if (p < 97)
      it.action = 4'($urandom_range(ptt_pkg::ACT_GET_ADDR, ptt_pkg::ACT_COUNT));
    else if (p < 98) it.action = ptt_pkg::ACT_CLEAR;
    else it.action = 4'($urandom_range(9, 15));
    return it;
  endfunction

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic test_directed();
    ptt_pkg::in_item_t it;
    send_item(make_item(ptt_pkg::ACT_COUNT, ptt_pkg::MODE_EXT, '0, '0, 1'b0, '0, '0, '0));
    send_item(make_item(ptt_pkg::ACT_GET_ADDR, ptt_pkg::MODE_EXT, '0, '0, 1'b0, '0, '0,
                        '0));
    for (int i = 0; i < DEPTH; i++)
      send_item(make_item(ptt_pkg::ACT_ADD,
                          (i % 2) ? ptt_pkg::MODE_SHORT : ptt_pkg::MODE_EXT,
                          (i == 0) ? '1 : {48'hABCD_0000_0000, 16'(i)},
                          (i == 0) ? 16'hFFFF : 16'(i), 1'b0, (i == 0) ? 8'hFF : 8'(i),
                          (i == 0) ? 32'hFFFF_FFFF : 32'(i * 10), 32'hFFFF_FF00));
    // table full, nothing expired
    send_item(make_item(ptt_pkg::ACT_ADD, ptt_pkg::MODE_EXT, 64'h5, 16'h5, 1'b0, 8'h5,
                        32'd1, 32'hFFFF_FF00));
    send_item(make_item(ptt_pkg::ACT_GET_ADDR, ptt_pkg::MODE_SHORT, 64'hFFFF_0000_0000_0001,
                        '0, 1'b0, '0, '0, '0));
    send_item(make_item(ptt_pkg::ACT_GET_ADDR, 2'd0, '0, '0, 1'b0, '0, '0, '0));
    send_item(make_item(ptt_pkg::ACT_GET_ADDR, 2'd1, '1, '0, 1'b0, '0, '0, '0));
    send_item(make_item(ptt_pkg::ACT_CHK_SEC, ptt_pkg::MODE_SHORT, 64'h1, '0, 1'b0, '0,
                        '0, '0));
    send_item(make_item(ptt_pkg::ACT_CHK_TAG, ptt_pkg::MODE_EXT, '0, 16'hFFFF, 1'b1, '0,
                        '0, 32'hFFFF_FF00));
    send_item(make_item(ptt_pkg::ACT_DEL_TAG, ptt_pkg::MODE_EXT, '0, '0, 1'b0, 8'h3, '0,
                        '0));
    send_item(make_item(ptt_pkg::ACT_DEL_ADDR, ptt_pkg::MODE_SHORT, 64'h5, '0, 1'b0, '0,
                        '0, '0));
    // later time: every entry but the saturated one expires at once
    send_item(make_item(ptt_pkg::ACT_CHK_ADDR, ptt_pkg::MODE_EXT, '1, '0, 1'b0, '0, '0,
                        32'hFFFF_FFFF));
    send_item(make_item(ptt_pkg::ACT_COUNT, ptt_pkg::MODE_EXT, '0, '0, 1'b0, '0, '0,
                        32'hFFFF_FFFF));
    it = make_item(ptt_pkg::ACT_ADD, ptt_pkg::MODE_SHORT, 64'h1234, 16'h1, 1'b0, 8'h1,
                   32'd0, 32'd0);
    send_item(it);
    send_item(it);
    send_item(make_item(ptt_pkg::ACT_CHK_SEC, ptt_pkg::MODE_SHORT, 64'h9999_1234, '0,
                        1'b0, '0, '0, '0));
    send_item(make_item(ptt_pkg::action_e'(4'd15), ptt_pkg::MODE_EXT, '1, '1, 1'b1, '1,
                        '1, '1));
    send_item(make_item(ptt_pkg::action_e'(4'd9), ptt_pkg::MODE_EXT, '0, '0, 1'b0, '0,
                        '0, '0));
    send_item(make_item(ptt_pkg::ACT_CLEAR, ptt_pkg::MODE_EXT, '0, '0, 1'b0, '0, '0, '0));
    wait_drained();
  endtask

  task automatic test_random(int items, int idle, int stall);
    send_idle = idle;
    recv_stall = stall;
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(49) == 0) begin
        addr_pool[$urandom_range(3)] = {$urandom, $urandom};
        tag_pool[$urandom_range(3)] = 16'($urandom);
        hdl_pool[$urandom_range(3)] = 8'($urandom);
      end
      send_item(random_item());
    end
    wait_drained();
  endtask

  initial begin
    foreach (addr_pool[i]) begin
      addr_pool[i] = {$urandom, $urandom};
      tag_pool[i] = 16'($urandom);
      hdl_pool[i] = 8'($urandom);
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(200, 0, 0);
    test_random(200, 72, 0);
    test_random(200, 0, 72);
    test_random(200, 30, 30);
    send_idle = 0;
    recv_stall = 0;
    if (errors == 0) $display("pending_transaction_table_unit_test passed");
    else $display("pending_transaction_table_unit_test failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("pending_transaction_table_unit_test failed");
    $finish;
  end

endmodule
